// ===== src/cle_pkg.sv =====
package cle_pkg;

    localparam int CFG_W         = 16;
    localparam int IDLE_W        = 16;
    localparam int LF_W          = 10;
    localparam int LEN_W         = 5;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;

    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RESET = 16'd30000;
    localparam logic [LF_W-1:0]   LF_WAIT_RESET      = 10'd50;
    localparam logic [IDLE_W-1:0] IDLE_MAX           = 16'hffff;
    localparam logic [LF_W-1:0]   LF_MAX             = 10'h3ff;

    // configuration register indexes
    localparam logic CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic CFG_LF_WAIT      = 1'b1;

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_ECHO     = 2'd0;
    localparam logic [1:0] KIND_LINE     = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_DISCARD  = 2'd3;

    // byte values
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] line_length;
        logic             last;
    } out_item_t;

    typedef enum logic [2:0] {
        CLS_TICK,
        CLS_NUL,
        CLS_CR,
        CLS_LF,
        CLS_ERASE,
        CLS_PRINT,
        CLS_OTHER
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        logic [7:0] rx_byte;
    } cmd_t;

endpackage

// ===== src/cle_front.sv =====
module cle_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cle_pkg::in_item_t in_item,
    output logic              q_push,
    output cle_pkg::cmd_t     q_wdata,
    input  logic              q_ready
);

    logic          valid_reg;
    logic          valid_next;
    cle_pkg::cmd_t cmd_reg;
    cle_pkg::cmd_t cmd_next;
    cle_pkg::cls_t cls;
    logic          accept;

    always_comb
    begin
        if (in_item.op == cle_pkg::OP_TICK)
        begin
            cls = cle_pkg::CLS_TICK;
        end
        else
        begin
            case (in_item.rx_byte)
                cle_pkg::CH_NUL: cls = cle_pkg::CLS_NUL;
                cle_pkg::CH_CR:  cls = cle_pkg::CLS_CR;
                cle_pkg::CH_LF:  cls = cle_pkg::CLS_LF;
                cle_pkg::CH_BS,
                cle_pkg::CH_DEL: cls = cle_pkg::CLS_ERASE;
                default:
                begin
                    if (in_item.rx_byte inside {[cle_pkg::CH_SPACE:8'h7e]})
                        cls = cle_pkg::CLS_PRINT;
                    else
                        cls = cle_pkg::CLS_OTHER;
                end
            endcase
        end
    end

    assign in_stall = valid_reg && !q_ready;
    assign accept   = in_valid && !in_stall;
    assign q_push   = valid_reg && q_ready;
    assign q_wdata  = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (accept)
        begin
            valid_next       = 1'b1;
            cmd_next.cls     = cls;
            cmd_next.rx_byte = in_item.rx_byte;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// ===== src/cle_queue.sv =====
module cle_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cle_pkg::cmd_t wdata,
    output logic          ready,
    input  logic          pop,
    output logic          valid,
    output cle_pkg::cmd_t rdata
);

    cle_pkg::cmd_t                entry_reg [cle_pkg::QUEUE_DEPTH];
    logic [cle_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [cle_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [cle_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [cle_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [cle_pkg::QCNT_W-1:0]   count_reg;
    logic [cle_pkg::QCNT_W-1:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    localparam logic [cle_pkg::QPTR_W-1:0] PTR_LAST = cle_pkg::QPTR_W'(cle_pkg::QUEUE_DEPTH - 1);
    localparam logic [cle_pkg::QCNT_W-1:0] CNT_FULL = cle_pkg::QCNT_W'(cle_pkg::QUEUE_DEPTH);

    assign ready   = count_reg != CNT_FULL;
    assign valid   = count_reg != '0;
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== src/cle_back.sv =====
module cle_back
#(
    parameter int LINE_BYTES = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  cle_pkg::cmd_t                q_data,
    output logic                         q_pop,
    input  logic [cle_pkg::IDLE_W-1:0]   idle_timeout,
    input  logic [cle_pkg::LF_W-1:0]     lf_wait,
    output logic                         out_valid,
    input  logic                         out_stall,
    output cle_pkg::out_item_t           out_item
);

    localparam int IDX_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam logic [IDX_W-1:0] COUNT_MAX = IDX_W'(LINE_BYTES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP_RD,
        ST_DUMP_OUT,
        ST_DONE,
        ST_TAKE,
        ST_ERASE_SP,
        ST_ERASE_BS
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    cle_pkg::cmd_t                cmd_reg;
    cle_pkg::cmd_t                cmd_next;
    logic [IDX_W-1:0]             count_reg;
    logic [IDX_W-1:0]             count_next;
    logic [IDX_W-1:0]             idx_reg;
    logic [IDX_W-1:0]             idx_next;
    logic                         cr_pending_reg;
    logic                         cr_pending_next;
    logic [cle_pkg::LF_W-1:0]     lf_cnt_reg;
    logic [cle_pkg::LF_W-1:0]     lf_cnt_next;
    logic [cle_pkg::IDLE_W-1:0]   idle_cnt_reg;
    logic [cle_pkg::IDLE_W-1:0]   idle_cnt_next;
    logic                         active_reg;
    logic                         active_next;
    logic                         take_reg;
    logic                         take_next;
    logic                         done_last_reg;
    logic                         done_last_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    cle_pkg::out_item_t           out_reg;
    cle_pkg::out_item_t           out_next;

    logic [7:0]                   line_store [LINE_BYTES];
    logic [7:0]                   rd_data_reg;
    logic                         mem_we;
    logic                         rd_en;

    logic                         slot_free;
    logic                         emit;
    cle_pkg::out_item_t           emit_item;
    logic [cle_pkg::IDLE_W-1:0]   idle_inc;
    logic [cle_pkg::LF_W-1:0]     lf_inc;
    logic [31:0]                  count_ext;
    logic                         take_emits;
    logic                         take_needs_slot;
    cle_pkg::cls_t                cls;

    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign q_pop     = q_valid && (state_reg == ST_IDLE);
    assign cls       = cmd_reg.cls;
    assign count_ext = 32'(count_reg);

    assign idle_inc = (idle_cnt_reg == cle_pkg::IDLE_MAX) ? idle_cnt_reg : idle_cnt_reg + 1'b1;
    assign lf_inc   = (cr_pending_reg && lf_cnt_reg != cle_pkg::LF_MAX) ? lf_cnt_reg + 1'b1
                                                                         : lf_cnt_reg;

    // after a line ends the store is empty, so only these classes echo
    assign take_emits = (cls == cle_pkg::CLS_CR) || (cls == cle_pkg::CLS_LF) ||
                        (cls == cle_pkg::CLS_PRINT);

    assign take_needs_slot = (cls == cle_pkg::CLS_CR) || (cls == cle_pkg::CLS_LF) ||
                             (cls == cle_pkg::CLS_ERASE && count_reg != '0) ||
                             (cls == cle_pkg::CLS_PRINT && count_reg < COUNT_MAX);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cr_pending_next = cr_pending_reg;
        lf_cnt_next     = lf_cnt_reg;
        idle_cnt_next   = idle_cnt_reg;
        active_next     = active_reg;
        take_next       = take_reg;
        done_last_next  = done_last_reg;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        emit            = 1'b0;
        emit_item       = '{kind: cle_pkg::KIND_ECHO, data: 8'h00,
                            line_length: '0, last: 1'b0};

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next   = q_data;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (cls == cle_pkg::CLS_TICK)
                begin
                    if (!active_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (idle_inc >= idle_timeout)
                    begin
                        if (slot_free)
                        begin
                            emit            = 1'b1;
                            emit_item.kind  = cle_pkg::KIND_DISCARD;
                            emit_item.last  = 1'b1;
                            count_next      = '0;
                            cr_pending_next = 1'b0;
                            lf_cnt_next     = '0;
                            idle_cnt_next   = '0;
                            active_next     = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                    else if (cr_pending_reg && lf_inc >= lf_wait)
                    begin
                        take_next      = 1'b0;
                        done_last_next = 1'b1;
                        idx_next       = '0;
                        state_next     = ST_DUMP_RD;
                    end
                    else
                    begin
                        idle_cnt_next = idle_inc;
                        lf_cnt_next   = lf_inc;
                        state_next    = ST_IDLE;
                    end
                end
                else if (cr_pending_reg)
                begin
                    if (cls == cle_pkg::CLS_LF)
                    begin
                        if (slot_free)
                        begin
                            emit           = 1'b1;
                            emit_item.data = cle_pkg::CH_LF;
                            take_next      = 1'b0;
                            done_last_next = 1'b1;
                            idx_next       = '0;
                            state_next     = ST_DUMP_RD;
                        end
                    end
                    else
                    begin
                        // line ends, then the byte (a NUL excepted) starts the next one
                        take_next      = (cls != cle_pkg::CLS_NUL);
                        done_last_next = !take_emits;
                        idx_next       = '0;
                        state_next     = ST_DUMP_RD;
                    end
                end
                else
                begin
                    state_next = ST_TAKE;
                end
            end

            ST_DUMP_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_DUMP_OUT;
                end
            end

            ST_DUMP_OUT:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    emit_item.kind = cle_pkg::KIND_LINE;
                    emit_item.data = rd_data_reg;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = ST_DUMP_RD;
                end
            end

            ST_DONE:
            begin
                if (slot_free)
                begin
                    emit                  = 1'b1;
                    emit_item.kind        = cle_pkg::KIND_COMPLETE;
                    emit_item.line_length = count_ext[cle_pkg::LEN_W-1:0];
                    emit_item.last        = done_last_reg;
                    count_next            = '0;
                    cr_pending_next       = 1'b0;
                    lf_cnt_next           = '0;
                    idle_cnt_next         = '0;
                    active_next           = 1'b0;
                    state_next            = take_reg ? ST_TAKE : ST_IDLE;
                end
            end

            ST_TAKE:
            begin
                if (cls == cle_pkg::CLS_NUL)
                begin
                    state_next = ST_IDLE;
                end
                else if (!take_needs_slot || slot_free)
                begin
                    active_next   = 1'b1;
                    idle_cnt_next = '0;
                    state_next    = ST_IDLE;
                    case (cls)
                        cle_pkg::CLS_CR:
                        begin
                            emit            = 1'b1;
                            emit_item.data  = cle_pkg::CH_CR;
                            emit_item.last  = 1'b1;
                            cr_pending_next = 1'b1;
                            lf_cnt_next     = '0;
                        end
                        cle_pkg::CLS_LF:
                        begin
                            emit           = 1'b1;
                            emit_item.data = cle_pkg::CH_LF;
                            take_next      = 1'b0;
                            done_last_next = 1'b1;
                            idx_next       = '0;
                            state_next     = ST_DUMP_RD;
                        end
                        cle_pkg::CLS_ERASE:
                        begin
                            if (count_reg != '0)
                            begin
                                emit           = 1'b1;
                                emit_item.data = cle_pkg::CH_BS;
                                state_next     = ST_ERASE_SP;
                            end
                        end
                        cle_pkg::CLS_PRINT:
                        begin
                            if (count_reg < COUNT_MAX)
                            begin
                                emit           = 1'b1;
                                emit_item.data = cmd_reg.rx_byte;
                                emit_item.last = 1'b1;
                                mem_we         = 1'b1;
                                count_next     = count_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            // other control bytes only keep the line alive
                        end
                    endcase
                end
            end

            ST_ERASE_SP:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    emit_item.data = cle_pkg::CH_SPACE;
                    state_next     = ST_ERASE_BS;
                end
            end

            ST_ERASE_BS:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    emit_item.data = cle_pkg::CH_BS;
                    emit_item.last = 1'b1;
                    count_next     = count_reg - 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (slot_free)
        begin
            out_valid_next = emit;
            if (emit)
                out_next = emit_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            cr_pending_reg <= 1'b0;
            lf_cnt_reg     <= '0;
            idle_cnt_reg   <= '0;
            active_reg     <= 1'b0;
            take_reg       <= 1'b0;
            done_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            cr_pending_reg <= cr_pending_next;
            lf_cnt_reg     <= lf_cnt_next;
            idle_cnt_reg   <= idle_cnt_next;
            active_reg     <= active_next;
            take_reg       <= take_next;
            done_last_reg  <= done_last_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    // line store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_store[count_reg] <= cmd_reg.rx_byte;
        if (rd_en)
            rd_data_reg <= line_store[idx_reg];
    end

endmodule

// ===== src/console_line_editor.sv =====
// console line editor: builds text lines from received console bytes and 1 ms ticks
// input channel (in_valid / in_stall / in_item): op 0 carries a received byte,
//   op 1 a millisecond tick; an item transfers when in_valid is high and in_stall low
// output channel (out_valid / out_stall / out_item): echo bytes, line bytes, a line
//   complete item with the length, or a discard item; last marks the final result
//   of one input item, and an input item may give none
// config port: cfg_write with cfg_index 0 sets the idle timeout in ticks,
//   index 1 the wait for an optional line feed after carriage return
// path: an item passes a register stage, a two-entry queue and the back sequencer,
//   whose results leave through the output register
// sequencing: the back sequencer takes a new item from the queue only once it is back
//   in idle; an erase gives backspace, space, backspace; at line end it reads each stored
//   byte from the store, sends it through the output register, then sends the completion
// receiver stall: the output register holds its result, the sequencer waits when it has
//   a result to give, the queue fills and then in_stall rises
// reset: stored line dropped, counters cleared, registers back to 30000 and 50
module console_line_editor
#(
    parameter int LINE_BYTES = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cle_pkg::in_item_t           in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cle_pkg::out_item_t          out_item,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [cle_pkg::CFG_W-1:0]   cfg_data
);

    logic [cle_pkg::IDLE_W-1:0] idle_timeout_reg;
    logic [cle_pkg::LF_W-1:0]   lf_wait_reg;
    logic                       q_push;
    logic                       q_ready;
    logic                       q_pop;
    logic                       q_valid;
    cle_pkg::cmd_t              q_wdata;
    cle_pkg::cmd_t              q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= cle_pkg::IDLE_TIMEOUT_RESET;
            lf_wait_reg      <= cle_pkg::LF_WAIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cle_pkg::CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data[cle_pkg::IDLE_W-1:0];
                cle_pkg::CFG_LF_WAIT:      lf_wait_reg      <= cfg_data[cle_pkg::LF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    cle_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_push   (q_push),
        .q_wdata  (q_wdata),
        .q_ready  (q_ready)
    );

    cle_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .ready (q_ready),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    cle_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .idle_timeout (idle_timeout_reg),
        .lf_wait      (lf_wait_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item)
    );

`ifndef SYNTHESIS
    // the front only hands over an item when the queue has room
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("queue written while full");

    // a discard is always the only and final result of its tick
    a_discard_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.kind == cle_pkg::KIND_DISCARD)
            |-> (out_item.last && out_item.data == 8'h00))
        else $error("discard result not final or carries data");

    // line bytes are always followed by the completion
    a_line_byte_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.kind == cle_pkg::KIND_LINE) |-> !out_item.last)
        else $error("line byte marked as final result");

    // the sequencer never pops an empty queue
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule
